>>> design/snds_pkg.sv
// Shared constants, register codes and a helper function for the neighbor difference sum block.
package snds_pkg;

    localparam int unsigned PIXEL_W       = 24;
    localparam int unsigned CHAN_W        = 8;
    localparam int unsigned NUM_CHAN      = 3;
    localparam int unsigned SQ_W          = 2 * CHAN_W;
    localparam int unsigned NUM_TERMS     = 2 * NUM_CHAN;
    localparam int unsigned ENERGY_W      = SQ_W + 3;
    localparam int unsigned SUM_W         = 43;
    localparam int unsigned CFG_W         = 13;
    localparam int unsigned ROW_W         = 12;
    localparam int unsigned APB_DATA_W    = 32;
    localparam int unsigned APB_ADDR_W    = 3;
    localparam int unsigned DEF_MAX_WIDTH = 4096;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd4096;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd4096;
    localparam logic [ROW_W-1:0] ROW_LAST     = '1;

    // Register select taken from the word address bit.
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    // Squared absolute difference of one 8-bit channel.
    function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        logic [SQ_W-1:0]   dx;
        d  = (a >= b) ? (a - b) : (b - a);
        dx = {{(SQ_W-CHAN_W){1'b0}}, d};
        return dx * dx;
    endfunction

endpackage

>>> design/snds_ram.sv
// Generic single-clock RAM with one write port and one registered read port (read-first).
module snds_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read and a write to the same entry in one cycle return the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/squared_neighbor_difference_sum.sv
// Top level: frame energy of an RGB pixel stream against the pixels above and to the left.
//
//  Channel     Handshake                   Payload                 Direction
//  pixel       pixel_valid / pixel_stall   pixel_word  [23:0]      in
//  energy      energy_valid / energy_stall energy_sum  [42:0]      out
//  config      APB (psel, penable, ...)    image_width, image_height
//
// One pixel transaction is taken every clock cycle while not stalled. The line store is
// read and written at the same column in the cycle a pixel is accepted, so its single write
// port and single read port set that rate. A frame result passes stages one to three and the
// output register after the last pixel of the frame is accepted. Reset clears the counters,
// left pixel, running sum and pipeline; the line store is not cleared, since every entry is
// written in the first row before it is used. The pixel channel stalls only while a result
// waits on a stalled energy channel and the next frame result has reached the accumulator.
module squared_neighbor_difference_sum
    import snds_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [PIXEL_W-1:0]    pixel_word,

    output logic                  energy_valid,
    input  logic                  energy_stall,
    output logic [SUM_W-1:0]      energy_sum
);

    localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers. The word address bit selects the register.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    cfg_reg_t         reg_sel;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_WIDTH:  image_width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: image_height_reg <= pwdata[CFG_W-1:0];
                default:    image_width_reg  <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control. Every stage moves together; the whole pipeline holds
    // only when the accumulator has a frame result and the output is still full.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_last_reg,  s2_last_reg,  s3_last_reg;
    logic energy_valid_reg;
    logic blocked;
    logic advance;
    logic pixel_accept;

    assign blocked      = s3_valid_reg && s3_last_reg && energy_valid_reg && energy_stall;
    assign advance      = !blocked;
    assign pixel_stall  = blocked;
    assign pixel_accept = pixel_valid && !pixel_stall;

    // ------------------------------------------------------------------
    // Raster position. A row ends when the next column reaches the width,
    // and a frame ends at the end of the row that reaches the height. A width
    // of zero behaves as one because the compare is already true at column zero.
    // ------------------------------------------------------------------
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PIXEL_W-1:0] left_pixel_reg, left_pixel_next;
    logic [COL_W:0]     col_inc;
    logic [CFG_W-1:0]   row_inc;
    logic               col_end;
    logic               row_end;
    logic               neighbors_ok;

    assign col_inc      = {1'b0, col_reg} + (COL_W+1)'(1);
    assign row_inc      = {1'b0, row_reg} + CFG_W'(1);
    assign col_end      = (CMP_W'(col_inc) >= CMP_W'(image_width_reg)) || (col_reg == COL_LAST);
    assign row_end      = (row_inc >= image_height_reg) || (row_reg == ROW_LAST);
    assign neighbors_ok = (row_reg != '0) && (col_reg != '0);

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        left_pixel_next = left_pixel_reg;
        if (pixel_accept)
        begin
            left_pixel_next = pixel_word;
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            left_pixel_reg <= '0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            left_pixel_reg <= left_pixel_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store. The entry for this column is read (old row) and overwritten
    // (current row) in the same cycle; the RAM returns the old contents, so no
    // forwarding is needed. The read is enabled only on acceptance, so the data
    // stays put while stage one holds.
    // ------------------------------------------------------------------
    logic [PIXEL_W-1:0] above_pixel;

    snds_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (pixel_accept),
        .wr_addr (col_reg),
        .wr_data (pixel_word),
        .rd_en   (pixel_accept),
        .rd_addr (col_reg),
        .rd_data (above_pixel)
    );

    // ------------------------------------------------------------------
    // Stage one: the accepted pixel, its left neighbor and frame flags.
    // ------------------------------------------------------------------
    logic [PIXEL_W-1:0] s1_pix_reg;
    logic [PIXEL_W-1:0] s1_left_reg;
    logic               s1_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pixel_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            s1_pix_reg  <= pixel_word;
            s1_left_reg <= left_pixel_reg;
            s1_use_reg  <= neighbors_ok;
            s1_last_reg <= col_end && row_end;
        end
    end

    // ------------------------------------------------------------------
    // Stage two: six channel squares, forced to zero on the first row or column
    // so that a line store entry that was never written cannot leak in.
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] sq_now  [NUM_TERMS];
    logic [SQ_W-1:0] s2_sq_reg [NUM_TERMS];

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            sq_now[c]            = chan_sq(s1_pix_reg[c*CHAN_W +: CHAN_W],
                                           above_pixel[c*CHAN_W +: CHAN_W]);
            sq_now[NUM_CHAN + c] = chan_sq(s1_pix_reg[c*CHAN_W +: CHAN_W],
                                           s1_left_reg[c*CHAN_W +: CHAN_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            for (int t = 0; t < NUM_TERMS; t++)
            begin
                s2_sq_reg[t] <= s1_use_reg ? sq_now[t] : '0;
            end
            s2_last_reg <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage three: pixel energy, the sum of the six squares.
    // ------------------------------------------------------------------
    logic [ENERGY_W-1:0] energy_now;
    logic [ENERGY_W-1:0] s3_energy_reg;

    always_comb
    begin
        energy_now = '0;
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            energy_now = energy_now + ENERGY_W'(s2_sq_reg[t]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            s3_energy_reg <= energy_now;
            s3_last_reg   <= s2_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Accumulator and output register. The frame total wraps at the sum width.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] running_sum_reg, running_sum_next;
    logic [SUM_W-1:0] energy_sum_reg;
    logic [SUM_W-1:0] sum_total;
    logic             energy_valid_next;
    logic             result_load;

    assign sum_total   = running_sum_reg + SUM_W'(s3_energy_reg);
    assign result_load = advance && s3_valid_reg && s3_last_reg;

    always_comb
    begin
        running_sum_next = running_sum_reg;
        if (advance && s3_valid_reg)
        begin
            running_sum_next = s3_last_reg ? '0 : sum_total;
        end
    end

    always_comb
    begin
        energy_valid_next = energy_valid_reg;
        if (result_load)
        begin
            energy_valid_next = 1'b1;
        end
        else if (!energy_stall)
        begin
            energy_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg  <= '0;
            energy_valid_reg <= 1'b0;
        end
        else
        begin
            running_sum_reg  <= running_sum_next;
            energy_valid_reg <= energy_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            energy_sum_reg <= sum_total;
        end
    end

    assign energy_valid = energy_valid_reg;
    assign energy_sum   = energy_sum_reg;

endmodule

>>> design/snds_checker.sv
// Port-level checker for the neighbor difference sum block, with its bind statement.
module snds_checker
    import snds_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             pixel_stall,
    input logic             energy_valid,
    input logic             energy_stall,
    input logic [SUM_W-1:0] energy_sum
);

    // A waiting result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        energy_valid && energy_stall |=> energy_valid)
        else $error("energy result dropped while stalled");

    // A waiting result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        energy_valid && energy_stall |=> $stable(energy_sum))
        else $error("energy result changed while stalled");

    // The pixel side is held back only by a result that cannot leave.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> energy_valid && energy_stall)
        else $error("pixel transaction stalled without output backpressure");

    // No result is offered right after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !energy_valid)
        else $error("energy result offered straight out of reset");

endmodule

bind squared_neighbor_difference_sum snds_checker u_snds_checker (.*);
